// File: design/serial_message_framer_queue_core_defines.svh
// assertion macros for the serial message framer queue
`ifndef SERIAL_MESSAGE_FRAMER_QUEUE_CORE_DEFINES_SVH
`define SERIAL_MESSAGE_FRAMER_QUEUE_CORE_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define SMFQ_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define SMFQ_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/smfq_pkg.sv
// shared types and constants for the serial message framer queue
`timescale 1ns / 1ps

package smfq_pkg;

    localparam int CFG_INDEX_W = 1;

    localparam logic [CFG_INDEX_W-1:0] REG_START_CHAR = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_END_CHAR   = 1'b1;

    localparam logic KIND_BYTE = 1'b0;
    localparam logic KIND_POP  = 1'b1;

    localparam logic [7:0] START_CHAR_RESET = 8'd94;
    localparam logic [7:0] END_CHAR_RESET   = 8'd10;

    typedef struct packed {
        logic       kind;
        logic [7:0] rx_byte;
    } req_item_t;

    typedef struct packed {
        logic [7:0] msg_char;
        logic       last;
        logic       none_ready;
    } rsp_item_t;

    typedef struct packed {
        logic [7:0] start_char;
        logic [7:0] end_char;
    } frame_cfg_t;

endpackage

// File: design/smfq_store.sv
// message slot store: one write port, one read port with registered data
`timescale 1ns / 1ps

module smfq_store #(
    parameter int ADDR_W = 7
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [7:0]        wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [7:0]        rd_data
);

    localparam int DEPTH = 2 ** ADDR_W;

    logic [7:0] mem_reg [0:DEPTH-1];
    logic [7:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: design/smfq_ctrl.sv
// framing and pop sequencing around the slot store
`timescale 1ns / 1ps

module smfq_ctrl #(
    parameter int SLOT_COUNT  = 4,
    parameter int SLOT_LENGTH = 32,
    parameter int ADDR_W      = $clog2(SLOT_COUNT) + $clog2(SLOT_LENGTH)
) (
    input  logic                clk,
    input  logic                rst_n,
    input  smfq_pkg::frame_cfg_t cfg,
    input  logic                req_valid,
    output logic                req_stall,
    input  smfq_pkg::req_item_t req,
    output logic                rsp_valid,
    input  logic                rsp_stall,
    output smfq_pkg::rsp_item_t rsp,
    output logic                wr_en,
    output logic [ADDR_W-1:0]   wr_addr,
    output logic [7:0]          wr_data,
    output logic                rd_en,
    output logic [ADDR_W-1:0]   rd_addr,
    input  logic [7:0]          rd_data
);

    import smfq_pkg::*;

    localparam int SLOT_W = $clog2(SLOT_COUNT);
    localparam int IDX_W  = $clog2(SLOT_LENGTH);
    localparam int POS_W  = $clog2(SLOT_LENGTH + 1);

    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(SLOT_COUNT - 1);
    localparam logic [IDX_W-1:0]  LAST_IDX  = IDX_W'(SLOT_LENGTH - 1);
    localparam logic [POS_W-1:0]  FULL_POS  = POS_W'(SLOT_LENGTH);

    typedef enum logic {
        ST_IDLE,
        ST_SEND
    } state_t;

    state_t             state_reg, state_next;
    logic               none_reg, none_next;
    logic [IDX_W-1:0]   idx_reg, idx_next;
    logic [SLOT_W-1:0]  wslot_reg, wslot_next;
    logic [POS_W-1:0]   wpos_reg, wpos_next;
    logic [SLOT_W-1:0]  rslot_reg, rslot_next;
    logic               full_reg, full_next;

    logic               req_fire;
    logic               rsp_fire;
    logic               empty;
    logic [SLOT_W-1:0]  wslot_inc;
    logic [SLOT_W-1:0]  rslot_inc;
    logic [POS_W-1:0]   pos_eff;
    logic [IDX_W-1:0]   pos_idx;
    logic [IDX_W-1:0]   idx_inc;
    logic               is_start;
    logic               is_end;
    logic               fin;

    assign req_stall = (state_reg == ST_SEND);
    assign rsp_valid = (state_reg == ST_SEND);
    assign req_fire  = req_valid && !req_stall;
    assign rsp_fire  = rsp_valid && !rsp_stall;

    assign empty     = !full_reg && (wslot_reg == rslot_reg);
    assign wslot_inc = (wslot_reg == LAST_SLOT) ? '0 : wslot_reg + 1'b1;
    assign rslot_inc = (rslot_reg == LAST_SLOT) ? '0 : rslot_reg + 1'b1;
    assign pos_eff   = (wpos_reg >= FULL_POS) ? '0 : wpos_reg;
    assign pos_idx   = pos_eff[IDX_W-1:0];
    assign idx_inc   = idx_reg + 1'b1;
    assign is_start  = (req.rx_byte == cfg.start_char);
    assign is_end    = (req.rx_byte == cfg.end_char);

    // end of the run: empty marker, matched end char past the start, or slot end
    assign fin = none_reg || ((idx_reg != '0) && (rd_data == cfg.end_char))
                 || (idx_reg == LAST_IDX);

    assign rsp.msg_char   = none_reg ? 8'd0 : rd_data;
    assign rsp.last       = fin;
    assign rsp.none_ready = none_reg;

    assign wr_data = req.rx_byte;

    always_comb
    begin
        state_next = state_reg;
        none_next  = none_reg;
        idx_next   = idx_reg;
        wslot_next = wslot_reg;
        wpos_next  = wpos_reg;
        rslot_next = rslot_reg;
        full_next  = full_reg;
        wr_en      = 1'b0;
        wr_addr    = {wslot_reg, pos_idx};
        rd_en      = 1'b0;
        rd_addr    = {rslot_reg, idx_inc};

        case (state_reg)
            ST_IDLE:
            begin
                if (req_fire)
                begin
                    if (req.kind == KIND_BYTE)
                    begin
                        if (!full_reg)
                        begin
                            if (is_start)
                            begin
                                // a start char always opens the slot afresh
                                wr_en     = 1'b1;
                                wr_addr   = {wslot_reg, {IDX_W{1'b0}}};
                                wpos_next = POS_W'(1);
                            end
                            else if (pos_eff == '0)
                            begin
                                wpos_next = '0;
                            end
                            else if (is_end)
                            begin
                                wr_en      = 1'b1;
                                wslot_next = wslot_inc;
                                full_next  = (wslot_inc == rslot_reg);
                                wpos_next  = '0;
                            end
                            else
                            begin
                                wr_en     = 1'b1;
                                wpos_next = pos_eff + 1'b1;
                            end
                        end
                    end
                    else
                    begin
                        state_next = ST_SEND;
                        idx_next   = '0;
                        if (empty)
                        begin
                            none_next = 1'b1;
                        end
                        else
                        begin
                            none_next = 1'b0;
                            rd_en     = 1'b1;
                            rd_addr   = {rslot_reg, {IDX_W{1'b0}}};
                        end
                    end
                end
            end
            ST_SEND:
            begin
                if (rsp_fire)
                begin
                    if (fin)
                    begin
                        state_next = ST_IDLE;
                        if (!none_reg)
                        begin
                            rslot_next = rslot_inc;
                            full_next  = 1'b0;
                        end
                    end
                    else
                    begin
                        rd_en    = 1'b1;
                        idx_next = idx_inc;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            none_reg  <= 1'b0;
            idx_reg   <= '0;
            wslot_reg <= '0;
            wpos_reg  <= '0;
            rslot_reg <= '0;
            full_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            none_reg  <= none_next;
            idx_reg   <= idx_next;
            wslot_reg <= wslot_next;
            wpos_reg  <= wpos_next;
            rslot_reg <= rslot_next;
            full_reg  <= full_next;
        end
    end

endmodule

// File: design/serial_message_framer_queue_core.sv
// top level of the serial message framer queue
// a received byte is written to the slot store in the cycle it is taken, unless full or outside a frame
// a pop's first result shows in the cycle after the transfer in, then one char per unstalled cycle
// a pop holds the input stalled while it streams its results
// reset clears the slot pointers, the full flag and the start and end chars to caret and newline
// store contents are not cleared; no clearing pass runs after reset
`timescale 1ns / 1ps
`include "serial_message_framer_queue_core_defines.svh"

module serial_message_framer_queue_core #(
    parameter int SLOT_COUNT  = 4,
    parameter int SLOT_LENGTH = 32
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [smfq_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [7:0]                    cfg_data,
    input  logic                          req_valid,
    output logic                          req_stall,
    input  smfq_pkg::req_item_t           req,
    output logic                          rsp_valid,
    input  logic                          rsp_stall,
    output smfq_pkg::rsp_item_t           rsp
);

    import smfq_pkg::*;

    localparam int ADDR_W = $clog2(SLOT_COUNT) + $clog2(SLOT_LENGTH);

    logic [7:0]        start_char_reg;
    logic [7:0]        end_char_reg;
    frame_cfg_t        cfg;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [7:0]        wr_data;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic [7:0]        rd_data;
    logic              pop_fire;
    logic              none_ok;

    assign cfg_ready      = 1'b1;
    assign cfg.start_char = start_char_reg;
    assign cfg.end_char   = end_char_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_char_reg <= START_CHAR_RESET;
            end_char_reg   <= END_CHAR_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_START_CHAR: start_char_reg <= cfg_data;
                REG_END_CHAR:   end_char_reg   <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    smfq_ctrl #(
        .SLOT_COUNT  (SLOT_COUNT),
        .SLOT_LENGTH (SLOT_LENGTH),
        .ADDR_W      (ADDR_W)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .rd_en     (rd_en),
        .rd_addr   (rd_addr),
        .rd_data   (rd_data)
    );

    smfq_store #(
        .ADDR_W (ADDR_W)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign pop_fire = req_valid && !req_stall && (req.kind == KIND_POP);
    assign none_ok  = rsp.last && (rsp.msg_char == 8'd0);

    `SMFQ_ASSERT_NOW(a_no_req_during_rsp, rsp_valid, req_stall, "input taken while a pop streams")
    `SMFQ_ASSERT_NEXT(a_pop_gives_rsp, pop_fire, rsp_valid, "pop transfer not followed by a result")
    `SMFQ_ASSERT_NOW(a_none_is_final, rsp_valid && rsp.none_ready, none_ok, "bad empty marker")
    `SMFQ_ASSERT_NOW(a_no_write_while_reading, rd_en, !wr_en, "store read and write together")

endmodule
